// File: src/twma_pkg.sv
// Package for the time-window moving average: payload structs, widths,
// queue and divider handshake types, back-end state encoding.
// No dependencies.
`timescale 1ns / 1ps

package twma_pkg;

  // Ring size; a power of two so that slot arithmetic wraps by truncation.
  localparam int RING_DEPTH    = 64;
  localparam int IDX_W         = $clog2(RING_DEPTH);
  localparam int CNT_W         = $clog2(RING_DEPTH + 1);
  localparam int TIME_W        = 32;
  localparam int VALUE_W       = 16;
  localparam int WIN_W         = 16;
  localparam int SUM_W         = 23;
  localparam int MEAN_W        = 24;
  localparam int FRAC_W        = 8;
  localparam int DIVD_W        = SUM_W + FRAC_W;
  localparam int STEP_W        = $clog2(DIVD_W + 1);
  localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd10;

  typedef struct packed {
    logic [TIME_W-1:0]         sample_time;
    logic signed [VALUE_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic signed [MEAN_W-1:0] window_mean;
    logic [CNT_W-1:0]         window_count;
  } out_item_t;

  // Queued beat: the reading plus its eviction limit.
  typedef struct packed {
    logic [TIME_W-1:0]         sample_time;
    logic signed [VALUE_W-1:0] sample_value;
    logic [TIME_W-1:0]         limit_time;
    logic                      evict_ok;
  } q_item_t;

  typedef struct packed {
    logic              start;
    logic              negate;
    logic [DIVD_W-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [MEAN_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_APPEND,
    ST_LAUNCH,
    ST_WAIT
  } back_state_t;

endpackage

// File: src/twma_front.sv
// Front end: window length register, eviction limit per beat, two-entry queue.
// Depends on twma_pkg.
`timescale 1ns / 1ps

module twma_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [twma_pkg::WIN_W-1:0] cfg_window_length,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  twma_pkg::in_item_t         in_data,
  output logic                       q_valid,
  output twma_pkg::q_item_t          q_item,
  input  logic                       q_pop
);

  logic [twma_pkg::WIN_W-1:0] window_r;
  twma_pkg::q_item_t          fifo_r [2];
  logic                       wptr_r;
  logic                       rptr_r;
  logic [1:0]                 fill_r;
  twma_pkg::q_item_t          entry;
  logic                       push;

  assign cfg_ready = 1'b1;
  assign in_ready  = (fill_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign q_valid   = (fill_r != 2'd0);
  assign q_item    = fifo_r[rptr_r];

  // A stored entry t expires when t + window <= now, i.e. now >= window and
  // t <= now - window.
  always_comb begin
    entry.sample_time  = in_data.sample_time;
    entry.sample_value = in_data.sample_value;
    entry.evict_ok     = (in_data.sample_time >= twma_pkg::TIME_W'(window_r));
    entry.limit_time   = in_data.sample_time - twma_pkg::TIME_W'(window_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= twma_pkg::WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      window_r <= cfg_window_length;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wptr_r] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (q_pop) begin
        rptr_r <= ~rptr_r;
      end
      case ({push, q_pop})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

// File: src/twma_div.sv
// Restoring divider, one quotient bit per cycle, sign applied at the end.
// Depends on twma_pkg.
`timescale 1ns / 1ps

module twma_div (
  input  logic               clk,
  input  logic               rst_n,
  input  twma_pkg::div_req_t req,
  output twma_pkg::div_rsp_t rsp
);

  logic [twma_pkg::DIVD_W-1:0] quo_r;
  logic [twma_pkg::CNT_W-1:0]  rem_r;
  logic [twma_pkg::CNT_W-1:0]  den_r;
  logic                        neg_r;
  logic [twma_pkg::STEP_W-1:0] step_r;
  logic                        busy_r;
  logic                        done_r;
  logic [twma_pkg::CNT_W:0]    trial;
  logic                        fits;
  logic [twma_pkg::DIVD_W-1:0] signed_quo;

  assign trial      = {rem_r, quo_r[twma_pkg::DIVD_W-1]};
  assign fits       = (trial >= {1'b0, den_r});
  assign signed_quo = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = signed_quo[twma_pkg::MEAN_W-1:0];

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      den_r <= req.divisor;
      neg_r <= req.negate;
    end else if (busy_r) begin
      quo_r <= {quo_r[twma_pkg::DIVD_W-2:0], fits};
      rem_r <= fits ? twma_pkg::CNT_W'(trial - {1'b0, den_r})
                    : trial[twma_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= twma_pkg::STEP_W'(twma_pkg::DIVD_W);
    end else if (busy_r) begin
      step_r <= step_r - 1'b1;
      if (step_r == twma_pkg::STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

endmodule

// File: src/twma_back.sv
// Back end: sample rings, eviction walk, running sum, mean and output register.
// Depends on twma_pkg and twma_div.
`timescale 1ns / 1ps

module twma_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  twma_pkg::q_item_t   q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output twma_pkg::out_item_t out_data
);

  logic [twma_pkg::TIME_W-1:0]         time_mem  [twma_pkg::RING_DEPTH];
  logic signed [twma_pkg::VALUE_W-1:0] value_mem [twma_pkg::RING_DEPTH];
  logic [twma_pkg::TIME_W-1:0]         rd_time_r;
  logic signed [twma_pkg::VALUE_W-1:0] rd_value_r;

  twma_pkg::back_state_t               state_r, state_nxt;
  logic [twma_pkg::IDX_W-1:0]          oldest_r, oldest_nxt;
  logic [twma_pkg::CNT_W-1:0]          count_r, count_nxt;
  logic signed [twma_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  twma_pkg::q_item_t                   cur_r, cur_nxt;
  twma_pkg::out_item_t                 out_r, out_nxt;
  logic                                out_valid_r, out_valid_nxt;

  logic                                wr_en;
  logic [twma_pkg::IDX_W-1:0]          wr_slot;
  logic [twma_pkg::SUM_W-1:0]          sum_mag;
  twma_pkg::div_req_t                  div_req;
  twma_pkg::div_rsp_t                  div_rsp;

  assign q_pop     = (state_r == twma_pkg::ST_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign wr_slot   = oldest_r + count_r[twma_pkg::IDX_W-1:0];
  assign sum_mag   = sum_r[twma_pkg::SUM_W-1] ? (~sum_r + 1'b1) : sum_r;

  always_comb begin
    div_req.start    = (state_r == twma_pkg::ST_LAUNCH);
    div_req.negate   = sum_r[twma_pkg::SUM_W-1];
    div_req.dividend = {sum_mag, {twma_pkg::FRAC_W{1'b0}}};
    div_req.divisor  = count_r;
  end

  twma_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Ring ports: one write, one registered read always at the oldest slot.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[wr_slot]  <= cur_r.sample_time;
      value_mem[wr_slot] <= cur_r.sample_value;
    end
    rd_time_r  <= time_mem[oldest_r];
    rd_value_r <= value_mem[oldest_r];
  end

  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    cur_nxt       = cur_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    wr_en         = 1'b0;
    case (state_r)
      twma_pkg::ST_IDLE: begin
        if (q_valid) begin
          cur_nxt   = q_item;
          state_nxt = twma_pkg::ST_READ;
        end
      end
      twma_pkg::ST_READ: begin
        // read data for the oldest slot lands at the end of this cycle
        state_nxt = (count_r == '0) ? twma_pkg::ST_APPEND : twma_pkg::ST_CHECK;
      end
      twma_pkg::ST_CHECK: begin
        if (cur_r.evict_ok && (rd_time_r <= cur_r.limit_time)) begin
          sum_nxt    = sum_r - twma_pkg::SUM_W'(rd_value_r);
          oldest_nxt = oldest_r + 1'b1;
          count_nxt  = count_r - 1'b1;
          state_nxt  = twma_pkg::ST_READ;
        end else begin
          if (count_r == twma_pkg::CNT_W'(twma_pkg::RING_DEPTH)) begin
            sum_nxt    = sum_r - twma_pkg::SUM_W'(rd_value_r);
            oldest_nxt = oldest_r + 1'b1;
            count_nxt  = count_r - 1'b1;
          end
          state_nxt = twma_pkg::ST_APPEND;
        end
      end
      twma_pkg::ST_APPEND: begin
        wr_en     = 1'b1;
        sum_nxt   = sum_r + twma_pkg::SUM_W'(cur_r.sample_value);
        count_nxt = count_r + 1'b1;
        state_nxt = twma_pkg::ST_LAUNCH;
      end
      twma_pkg::ST_LAUNCH: begin
        state_nxt = twma_pkg::ST_WAIT;
      end
      twma_pkg::ST_WAIT: begin
        if (div_rsp.done && (!out_valid_r || out_ready)) begin
          out_nxt.window_mean  = div_rsp.quotient;
          out_nxt.window_count = count_r;
          out_valid_nxt        = 1'b1;
          state_nxt            = twma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = twma_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= twma_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r    <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

endmodule

// File: src/time_window_moving_average.sv
// Each beat taken from the queue is handled in turn: the eviction walk reads each
// candidate entry through the ring read port and checks it against the limit, the
// beat is appended, and the 31-step serial divider divides the sum by the count. The
// next beat is not taken until the result has been loaded into the output register.
// Reset (rst_n low, synchronous): window empty, running sum zero, window length
// 10, queue and output register empty. Ring contents are not cleared.
`timescale 1ns / 1ps

module time_window_moving_average (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration: window length in timestamp units
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [twma_pkg::WIN_W-1:0] cfg_window_length,
  // reading beats
  input  logic                       in_valid,
  output logic                       in_ready,
  input  twma_pkg::in_item_t         in_data,
  // result beats: Q.8 mean and entry count
  output logic                       out_valid,
  input  logic                       out_ready,
  output twma_pkg::out_item_t        out_data
);

  logic              q_valid;
  logic              q_pop;
  twma_pkg::q_item_t q_item;

  // Front: hold the window length, work out each beat's eviction limit and
  // queue it so the input side can accept up to two beats while the back end walks.
  twma_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_window_length (cfg_window_length),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data           (in_data),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop)
  );

  // Back: drop expired entries from the oldest, drop one more if the ring is
  // full, append, divide the sum by the count and hold the result beat until
  // it is taken.
  twma_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
